>>> design/wpd_pkg.sv
// package: widths, register codes, reset values and word types of the peak detector
`timescale 1ns / 1ps
`default_nettype none

package wpd_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int TIME_WIDTH  = 32;
  localparam int CFG_WIDTH   = 32;
  localparam int MODE_WIDTH  = 2;
  localparam int CFG_IDX_W   = 2;

  // compare widths that hold every operand exactly
  localparam int LIM_W = (VALUE_WIDTH > CFG_WIDTH) ? VALUE_WIDTH : CFG_WIDTH;
  localparam int GAP_W = (TIME_WIDTH + 1 > CFG_WIDTH) ? TIME_WIDTH + 1 : CFG_WIDTH;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_MODE = 2'd0,
    REG_ABOVE_LIMIT = 2'd1,
    REG_BELOW_LIMIT = 2'd2,
    REG_MIN_GAP     = 2'd3
  } wpd_reg_e;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_DIST2 = 2'd0,
    MODE_ADJ   = 2'd1,
    MODE_MONO  = 2'd2
  } wpd_mode_e;

  localparam logic [MODE_WIDTH-1:0] RST_WINDOW_MODE = MODE_MONO;
  localparam logic [CFG_WIDTH-1:0]  RST_ABOVE_LIMIT = 32'h8000_0000;
  localparam logic [CFG_WIDTH-1:0]  RST_BELOW_LIMIT = 32'h7FFF_FFFF;
  localparam logic [CFG_WIDTH-1:0]  RST_MIN_GAP     = CFG_WIDTH'(-32'sd99999);

  typedef struct packed {
    logic [MODE_WIDTH-1:0] window_mode;
    logic [CFG_WIDTH-1:0]  above_limit;
    logic [CFG_WIDTH-1:0]  below_limit;
    logic [CFG_WIDTH-1:0]  min_gap;
  } wpd_cfg_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [TIME_WIDTH-1:0]  stamp;
  } wpd_word_t;

endpackage

`default_nettype wire

>>> design/wpd_detect.sv
// sample window, peak shape test, limit test and gap test
`timescale 1ns / 1ps
`default_nettype none

module wpd_detect (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [wpd_pkg::VALUE_WIDTH-1:0] value_i,
  input  wire logic [wpd_pkg::TIME_WIDTH-1:0]  stamp_i,
  input  wire wpd_pkg::wpd_cfg_t             cfg_i,
  output logic                               emit_o,
  output wpd_pkg::wpd_word_t                 word_o
);
  import wpd_pkg::*;

  // window: index 0 one back, 1 candidate, 2 three back, 3 four back
  logic [VALUE_WIDTH-1:0] win_q [4];
  logic [TIME_WIDTH-1:0]  td_q  [2];
  logic [TIME_WIDTH-1:0]  last_q;

  logic signed [VALUE_WIDTH-1:0] a, b, c, d, e;
  logic signed [LIM_W-1:0]       c_ext, lo_ext, hi_ext;
  logic signed [GAP_W-1:0]       diff, gap_ext;
  logic                          shape, peak, gap_ok;

  always_comb begin
    a = value_i;
    b = win_q[0];
    c = win_q[1];
    d = win_q[2];
    e = win_q[3];
    unique case (cfg_i.window_mode)
      MODE_DIST2: shape = (c > a) && (c > e);
      MODE_ADJ:   shape = (c > b) && (c > d);
      MODE_MONO:  shape = (c >= b) && (b > a) && (c >= d) && (d > e);
      default:    shape = 1'b0;
    endcase
    c_ext  = LIM_W'(c);
    lo_ext = LIM_W'(signed'(cfg_i.above_limit));
    hi_ext = LIM_W'(signed'(cfg_i.below_limit));
    peak   = shape && (c_ext > lo_ext) && (c_ext < hi_ext);
    diff    = signed'(GAP_W'(td_q[1])) - signed'(GAP_W'(last_q));
    gap_ext = GAP_W'(signed'(cfg_i.min_gap));
    gap_ok  = diff >= gap_ext;
    emit_o       = accept_i && peak && gap_ok;
    word_o.value = win_q[1];
    word_o.stamp = td_q[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) win_q[i] <= '0;
      td_q[0] <= '0;
      td_q[1] <= '0;
      last_q  <= '0;
    end else if (accept_i) begin
      win_q[3] <= win_q[2];
      win_q[2] <= win_q[1];
      win_q[1] <= win_q[0];
      win_q[0] <= value_i;
      td_q[1]  <= td_q[0];
      td_q[0]  <= stamp_i;
      if (peak) begin
        last_q <= td_q[1];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/wpd_out_buf.sv
// two-word output buffer that decouples the result side from the sample side
`timescale 1ns / 1ps
`default_nettype none

module wpd_out_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire wpd_pkg::wpd_word_t push_word_i,
  output logic                    full_o,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output wpd_pkg::wpd_word_t      word_o
);
  import wpd_pkg::*;

  wpd_word_t   slot_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        pop;

  assign pop     = (cnt_q != 2'd0) && !stall_i;
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign word_o  = slot_q[0];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk_i) begin
    if (pop) begin
      slot_q[0] <= slot_q[1];
    end
    if (push_i) begin
      if (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)) begin
        slot_q[0] <= push_word_i;
      end else begin
        slot_q[1] <= push_word_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/windowed_peak_detector.sv
// top level of the windowed peak detector
//
//  channel  | direction | handshake                | word
//  ---------+-----------+--------------------------+------------------------------
//  sample   | in        | in_valid_i / in_stall_o  | sample_value_i, sample_time_i
//  peak     | out       | out_valid_o / out_stall_i| peak_value_o, peak_time_o
//  config   | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
//  one sample word per cycle while in_stall_o is low; a peak word enters the
//  output buffer when the sample two words behind it is taken and shows on the
//  output once the words ahead of it have left; in_stall_o rises only when both
//  output buffer slots hold words; reset clears the window, the last peak time,
//  the buffer and the registers to their defaults
`timescale 1ns / 1ps
`default_nettype none

module windowed_peak_detector (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [wpd_pkg::VALUE_WIDTH-1:0] sample_value_i,
  input  wire logic [wpd_pkg::TIME_WIDTH-1:0]  sample_time_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [wpd_pkg::VALUE_WIDTH-1:0]      peak_value_o,
  output logic [wpd_pkg::TIME_WIDTH-1:0]       peak_time_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [wpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wpd_pkg::CFG_WIDTH-1:0]   cfg_data_i
);
  import wpd_pkg::*;

  wpd_cfg_t  cfg_q;
  wpd_word_t det_word, out_word;
  logic      accept, emit, full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_mode <= RST_WINDOW_MODE;
      cfg_q.above_limit <= RST_ABOVE_LIMIT;
      cfg_q.below_limit <= RST_BELOW_LIMIT;
      cfg_q.min_gap     <= RST_MIN_GAP;
    end else if (cfg_we_i) begin
      unique case (wpd_reg_e'(cfg_idx_i))
        REG_WINDOW_MODE: cfg_q.window_mode <= cfg_data_i[MODE_WIDTH-1:0];
        REG_ABOVE_LIMIT: cfg_q.above_limit <= cfg_data_i;
        REG_BELOW_LIMIT: cfg_q.below_limit <= cfg_data_i;
        REG_MIN_GAP:     cfg_q.min_gap     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  wpd_detect u_detect (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .value_i  (sample_value_i),
    .stamp_i  (sample_time_i),
    .cfg_i    (cfg_q),
    .emit_o   (emit),
    .word_o   (det_word)
  );

  wpd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit),
    .push_word_i (det_word),
    .full_o      (full),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .word_o      (out_word)
  );

  assign peak_value_o = out_word.value;
  assign peak_time_o  = out_word.stamp;

endmodule

`default_nettype wire

>>> design/wpd_checker.sv
// port checker for the windowed peak detector and its bind
`timescale 1ns / 1ps
`default_nettype none

module wpd_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_o,
  input  wire logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  input  wire logic [wpd_pkg::VALUE_WIDTH-1:0] peak_value_o,
  input  wire logic [wpd_pkg::TIME_WIDTH-1:0]  peak_time_o
);

  // a stalled peak word stays and holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(peak_value_o)
      && $stable(peak_time_o))
    else $error("stalled peak word changed");

  // reset empties the output buffer
  a_rst_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && !in_stall_o)
    else $error("output not empty in reset");

  // input is held off only while buffered words wait
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a word taken from a full buffer frees the input
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after a word left a full buffer");

  // the buffer only fills when a peak word was already waiting
  a_stall_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o) && $past(in_valid_i))
    else $error("input stall rose without a waiting word");

endmodule

bind windowed_peak_detector wpd_checker u_wpd_checker (.*);

`default_nettype wire

>>> dv/tb.sv
// testbench for the windowed peak detector: directed, back-pressure and random sample streams
`timescale 1ns / 1ps

module tb;

  import wpd_pkg::*;

  localparam logic [31:0] VAL_MIN   = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX   = 32'h7FFF_FFFF;
  localparam logic [1:0]  MODE_NONE = 2'd3;
  localparam int          SETTLE    = 4;

  logic        clk        = 1'b0;
  logic        rst_n;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [31:0] sample_value = '0;
  logic [31:0] sample_time  = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [31:0] peak_value;
  logic [31:0] peak_time;
  logic        cfg_we     = 1'b0;
  wpd_reg_e    cfg_idx    = REG_WINDOW_MODE;
  logic [31:0] cfg_data   = '0;

  // window state and registers as the block should hold them
  logic signed [31:0] win [4];
  logic        [31:0] tdly [2];
  logic        [31:0] last_pk;
  logic        [1:0]  cur_mode;
  logic signed [31:0] cur_above;
  logic signed [31:0] cur_below;
  logic signed [31:0] cur_gap;

  wpd_word_t expected_peaks [$];

  int errors        = 0;
  int samples_taken = 0;
  int peaks_checked = 0;
  int settings      = 0;
  int hold_cycles   = 0;
  bit idle_on       = 1'b1;
  bit stall_on      = 1'b1;
  int phase_scale   = 1;
  logic [31:0] t_now = 32'd1000;

  windowed_peak_detector i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_value_i (sample_value),
    .sample_time_i  (sample_time),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .peak_value_o   (peak_value),
    .peak_time_o    (peak_time),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int k = 0; k < 4; k++) win[k] = '0;
    tdly[0]   = '0;
    tdly[1]   = '0;
    last_pk   = '0;
    cur_mode  = RST_WINDOW_MODE;
    cur_above = RST_ABOVE_LIMIT;
    cur_below = RST_BELOW_LIMIT;
    cur_gap   = RST_MIN_GAP;
  end

  task automatic step_window(input logic [31:0] a_raw, input logic [31:0] t);
    logic signed [31:0] a, b, c, d, e;
    logic               shape;
    longint             tdiff;
    wpd_word_t          w;
    a = a_raw;
    b = win[0];
    c = win[1];
    d = win[2];
    e = win[3];
    case (cur_mode)
      MODE_DIST2: shape = (c > a) && (c > e);
      MODE_ADJ:   shape = (c > b) && (c > d);
      MODE_MONO:  shape = (c >= b) && (b > a) && (c >= d) && (d > e);
      default:    shape = 1'b0;
    endcase
    if (shape && (c > cur_above) && (c < cur_below)) begin
      tdiff = longint'({1'b0, tdly[1]}) - longint'({1'b0, last_pk});
      last_pk = tdly[1];
      if (tdiff >= longint'(cur_gap)) begin
        w.value = c;
        w.stamp = tdly[1];
        expected_peaks.push_back(w);
      end
    end
    win[3]  = win[2];
    win[2]  = win[1];
    win[1]  = win[0];
    win[0]  = a;
    tdly[1] = tdly[0];
    tdly[0] = t;
  endtask

  always @(posedge clk) begin : monitor
    wpd_word_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_WINDOW_MODE: cur_mode  = cfg_data[1:0];
          REG_ABOVE_LIMIT: cur_above = cfg_data;
          REG_BELOW_LIMIT: cur_below = cfg_data;
          REG_MIN_GAP:     cur_gap   = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_peaks.size() == 0) begin
          $error("unexpected peak word: value %0d time %0d", $signed(peak_value), peak_time);
          errors++;
        end else begin
          want = expected_peaks.pop_front();
          peaks_checked++;
          if (peak_value !== want.value) begin
            $error("peak_value expected %0d actual %0d", $signed(want.value),
                   $signed(peak_value));
            errors++;
          end
          if (peak_time !== want.stamp) begin
            $error("peak_time expected %0d actual %0d", want.stamp, peak_time);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        step_window(sample_value, sample_time);
        samples_taken++;
      end
    end
  end

  initial begin : stall_gen
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_sample(input logic [31:0] v, input logic [31:0] t);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= v;
    sample_time  <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [31:0] above,
                            input logic [31:0] below, input logic [31:0] gap);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_WINDOW_MODE;
    cfg_data <= {30'($urandom()), mode};
    @(posedge clk);
    cfg_idx  <= REG_ABOVE_LIMIT;
    cfg_data <= above;
    @(posedge clk);
    cfg_idx  <= REG_BELOW_LIMIT;
    cfg_data <= below;
    @(posedge clk);
    cfg_idx  <= REG_MIN_GAP;
    cfg_data <= gap;
    @(posedge clk);
    cfg_we   <= 1'b0;
    settings++;
  endtask

  function automatic logic [31:0] small_value(input int span);
    return 32'((int'($urandom_range(0, 2 * span)) - span) * phase_scale);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 4))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return VAL_MIN + 32'd1;
          3: return VAL_MAX - 32'd1;
          default: return '0;
        endcase
      end
      default: return small_value(16);
    endcase
  endfunction

  function automatic logic [31:0] next_time();
    case ($urandom_range(0, 19))
      0: t_now = $urandom();
      1: t_now = t_now - $urandom_range(1, 30);
      default: t_now = t_now + $urandom_range(0, 40);
    endcase
    return t_now;
  endfunction

  // rising two, then falling two around a random centre
  task automatic send_bump();
    logic [31:0] v;
    v = small_value(16);
    send_sample(v, next_time());
    v = v + $urandom_range(1, 4) * phase_scale;
    send_sample(v, next_time());
    v = v + $urandom_range(0, 4) * phase_scale;
    send_sample(v, next_time());
    v = v - $urandom_range(0, 4) * phase_scale;
    send_sample(v, next_time());
    v = v - $urandom_range(1, 4) * phase_scale;
    send_sample(v, next_time());
  endtask

  // reset registers: zeros in the window at startup and values at both limits
  task automatic test_startup_window();
    logic [31:0] vals [13];
    vals = '{32'hFFFF_FFFD, 32'd7, 32'd9, 32'd2, 32'hFFFF_FFFC, 32'd1, 32'd5, VAL_MAX,
             32'd3, 32'hFFFF_FFFB, VAL_MIN, VAL_MIN, VAL_MIN};
    foreach (vals[k]) begin
      t_now = t_now + 32'd5;
      send_sample(vals[k], t_now);
    end
    drain();
  endtask

  // every window rule, with time going backwards
  task automatic test_each_mode();
    logic [31:0] vals [4];
    vals = '{32'd3, 32'd40, 32'd10, 32'hFFFF_FFEC};
    for (int m = 0; m < 4; m++) begin
      set_config(2'(m), 32'hFFFF_FFCE, 32'd50, (m % 2 == 0) ? 32'd2 : 32'hFFFF_FFFB);
      foreach (vals[k]) begin
        t_now = t_now - 32'd3;
        send_sample(vals[k], t_now);
      end
      drain();
    end
  endtask

  // long output hold while the sender keeps offering words
  task automatic test_backpressure();
    set_config(MODE_ADJ, VAL_MIN, VAL_MAX, VAL_MIN);
    idle_on     = 1'b0;
    stall_on    = 1'b0;
    hold_cycles = 80;
    for (int k = 0; k < 40; k++) begin
      t_now = t_now + 32'd1;
      send_sample((k % 2 == 0) ? 32'd1000 : 32'hFFFF_FC18, t_now);
    end
    drain();
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic pick_config(input int phase);
    logic [31:0] lo, hi, gap;
    lo  = small_value(20);
    hi  = 32'($signed(lo) + int'($urandom_range(4, 40)) * phase_scale);
    gap = 32'(int'($urandom_range(0, 120)) - 60);
    case (phase)
      0: set_config(MODE_DIST2, VAL_MIN, VAL_MAX, VAL_MIN);
      1: set_config(MODE_ADJ, lo, hi, VAL_MAX);
      2: set_config(MODE_MONO, VAL_MIN, VAL_MAX, 32'd0);
      3: set_config(MODE_ADJ, lo, hi, gap);
      4: set_config(MODE_NONE, VAL_MIN, VAL_MAX, gap);
      5: set_config(MODE_DIST2, lo, hi, gap);
      6: set_config(2'($urandom()), $urandom(), $urandom(), $urandom());
      7: set_config(MODE_MONO, lo, hi, gap);
      default: set_config(2'($urandom_range(0, 2)), VAL_MIN, VAL_MAX, gap);
    endcase
  endtask

  task automatic test_random_stream();
    int count;
    for (int phase = 0; phase < 9; phase++) begin
      drain();
      phase_scale = (phase % 2 == 1) ? 65536 : 1;
      pick_config(phase);
      if (phase == 8) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      count = 0;
      while (count < 120) begin
        if ($urandom_range(0, 3) == 0) begin
          send_bump();
          count += 5;
        end else begin
          send_sample(rand_value(), next_time());
          count++;
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_startup_window();
    test_each_mode();
    test_backpressure();
    test_random_stream();
    drain();
    repeat (10) @(posedge clk);
    if (expected_peaks.size() != 0) begin
      $error("%0d expected peak words never arrived", expected_peaks.size());
      errors++;
    end
    $display("covered %0d samples and %0d peak words under %0d register settings,",
             samples_taken, peaks_checked, settings);
    $display("all window modes, limit extremes, backward time and a long output hold");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
